### rtl/cnoise_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnoise_pkg
// Shared constants, codes and helpers of the 3d cellular noise evaluator.
// ----------------------------------------------------------------------------
package cnoise_pkg;

    // cell hash constants
    localparam logic [31:0] HASH_KX  = 32'd702395077;
    localparam logic [31:0] HASH_KY  = 32'd915488749;
    localparam logic [31:0] HASH_KZ  = 32'd2120969693;
    localparam logic [31:0] HASH_SQ  = 32'd15731;
    localparam logic [31:0] HASH_LIN = 32'd789221;
    localparam logic [31:0] HASH_ADD = 32'd1376312589;
    localparam logic [31:0] LCG_MUL  = 32'd1103515245;
    localparam logic [31:0] LCG_ADD  = 32'd12345;

    localparam int NUM_CELLS = 27;
    localparam int CELL_LAT  = 11;

    localparam logic [16:0] JIT_ONE = 17'd65536;

    // configuration register indexes
    localparam logic [1:0] CFG_JITTER = 2'd0;
    localparam logic [1:0] CFG_METRIC = 2'd1;
    localparam logic [1:0] CFG_MODE   = 2'd2;

    // metric codes
    localparam logic [1:0] METRIC_EUCLID    = 2'd0;
    localparam logic [1:0] METRIC_MANHATTAN = 2'd1;
    localparam logic [1:0] METRIC_CHEBYSHEV = 2'd2;

    // output mode codes
    localparam logic [1:0] MODE_F1   = 2'd0;
    localparam logic [1:0] MODE_F2   = 2'd1;
    localparam logic [1:0] MODE_DIFF = 2'd2;

    typedef struct packed {
        logic        en;
        logic [16:0] jit;
        logic [1:0]  metric;
    } cell_ctrl_t;

    // hash-sum contribution of a neighbor offset, wraps in 32 bits
    function automatic logic [31:0] offset_key(int ox, int oy, int oz);
        logic [31:0] r;
        r = 32'd0;
        if (ox > 0)
            r = r + HASH_KX;
        else if (ox < 0)
            r = r - HASH_KX;
        if (oy > 0)
            r = r + HASH_KY;
        else if (oy < 0)
            r = r - HASH_KY;
        if (oz > 0)
            r = r + HASH_KZ;
        else if (oz < 0)
            r = r - HASH_KZ;
        return r;
    endfunction

    // normalization constant in twentieths
    function automatic logic [5:0] norm_twentieths(logic [1:0] mi, logic [1:0] oi);
        logic [5:0] n;
        case ({mi, oi})
            {METRIC_EUCLID, MODE_F1}:      n = 6'd20;
            {METRIC_EUCLID, MODE_F2}:      n = 6'd30;
            {METRIC_EUCLID, MODE_DIFF}:    n = 6'd15;
            {METRIC_MANHATTAN, MODE_F1}:   n = 6'd30;
            {METRIC_MANHATTAN, MODE_F2}:   n = 6'd50;
            {METRIC_MANHATTAN, MODE_DIFF}: n = 6'd24;
            {METRIC_CHEBYSHEV, MODE_F1}:   n = 6'd12;
            {METRIC_CHEBYSHEV, MODE_F2}:   n = 6'd20;
            {METRIC_CHEBYSHEV, MODE_DIFF}: n = 6'd10;
            default:                       n = 6'd20;
        endcase
        return n;
    endfunction

    // ceil(2^32 / n), exact quotient for dividends below 2^22
    function automatic logic [28:0] norm_recip(logic [5:0] n);
        logic [28:0] m;
        case (n)
            6'd10:   m = 29'd429496730;
            6'd12:   m = 29'd357913942;
            6'd15:   m = 29'd286331154;
            6'd20:   m = 29'd214748365;
            6'd24:   m = 29'd178956971;
            6'd30:   m = 29'd143165577;
            6'd50:   m = 29'd85899346;
            default: m = 29'd214748365;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

### rtl/cnoise_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnoise_cell
// One neighbor cell: hashes its cell, places the feature point, measures the
// distance key and merges it into the running nearest / second nearest pair.
// ----------------------------------------------------------------------------
module cnoise_cell #(
    parameter int FRAC_BITS = 16,
    parameter int OX = 0,
    parameter int OY = 0,
    parameter int OZ = 0
) (
    input  wire logic                   clk,
    input  wire cnoise_pkg::cell_ctrl_t ctrl,
    input  wire logic [31:0]            s_in,
    input  wire logic [2:0][15:0]       frac_in,
    input  wire logic [2*FRAC_BITS+5:0] f1_in,
    input  wire logic [2*FRAC_BITS+5:0] f2_in,
    output logic      [31:0]            s_out,
    output logic      [2:0][15:0]       frac_out,
    output logic      [2*FRAC_BITS+5:0] f1_out,
    output logic      [2*FRAC_BITS+5:0] f2_out
);

    localparam int MW = FRAC_BITS + 2;
    localparam int KW = 2 * MW + 2;
    localparam int SH = 32 - FRAC_BITS;
    localparam logic [35:0] RND = 36'd1 << (31 - FRAC_BITS);
    localparam logic [31:0] OFFK = cnoise_pkg::offset_key(OX, OY, OZ);
    localparam logic signed [34:0] ONE_Q32 = 35'sd1 <<< 32;
    localparam logic signed [34:0] DX_OFF = (OX > 0) ? ONE_Q32 : (OX < 0) ? -ONE_Q32 : 35'sd0;
    localparam logic signed [34:0] DY_OFF = (OY > 0) ? ONE_Q32 : (OY < 0) ? -ONE_Q32 : 35'sd0;
    localparam logic signed [34:0] DZ_OFF = (OZ > 0) ? ONE_Q32 : (OZ < 0) ? -ONE_Q32 : 35'sd0;

    logic [31:0]            s_reg;
    logic [2:0][15:0]       fr_reg [0:6];
    logic [31:0]            n2_reg, n2_d1_reg, n2_d2_reg;
    logic [31:0]            sq_reg, t_reg;
    logic [31:0]            h0_reg, h0_d1_reg, h0_d2_reg;
    logic [31:0]            h1_reg, h1_d1_reg, h2_reg;
    logic signed [34:0]     px_reg, py_reg, pz_reg;
    logic [MW-1:0]          mx_reg, my_reg, mz_reg;
    logic [2*MW-1:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [MW+1:0]          alt_reg;
    logic [KW-1:0]          key_reg;
    logic [KW-1:0]          f1_reg, f2_reg;

    logic [31:0]            n_sum;
    logic [MW+1:0]          alt_next;
    logic [MW-1:0]          mxy_max;
    logic [KW-1:0]          f1_next, f2_next;

    function automatic logic signed [34:0] jit_pos(logic [31:0] h, logic [16:0] j);
        logic signed [17:0] js;
        logic signed [16:0] pd;
        logic signed [34:0] prod;
        js   = $signed({1'b0, j});
        pd   = $signed({1'b0, h[31:16]}) - 17'sd32768;
        prod = js * pd;
        return 35'sh80000000 + prod;
    endfunction

    // magnitude of a q32 difference, rounded half up
    function automatic logic [MW-1:0] mag(logic signed [34:0] d);
        logic [34:0] a;
        logic [35:0] s;
        a = (d < 0) ? 35'(-d) : 35'(d);
        s = {1'b0, a} + RND;
        return MW'(s >> SH);
    endfunction

    assign n_sum   = s_in + OFFK;
    assign mxy_max = (mx_reg > my_reg) ? mx_reg : my_reg;

    always_comb
    begin
        case (ctrl.metric)
            cnoise_pkg::METRIC_MANHATTAN:
                alt_next = (MW+2)'(mx_reg) + (MW+2)'(my_reg) + (MW+2)'(mz_reg);
            cnoise_pkg::METRIC_CHEBYSHEV:
                alt_next = (MW+2)'((mz_reg > mxy_max) ? mz_reg : mxy_max);
            default:
                alt_next = '0;
        endcase
    end

    // strict-less insertion keeps the earlier of equal keys
    always_comb
    begin
        f1_next = f1_in;
        f2_next = f2_in;
        if (key_reg < f1_in)
        begin
            f2_next = f1_in;
            f1_next = key_reg;
        end
        else if (key_reg < f2_in)
        begin
            f2_next = key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            s_reg     <= s_in;
            fr_reg[0] <= frac_in;
            for (int i = 1; i < 7; i++)
                fr_reg[i] <= fr_reg[i-1];
            n2_reg    <= n_sum ^ (n_sum << 13);
            n2_d1_reg <= n2_reg;
            n2_d2_reg <= n2_d1_reg;
            sq_reg    <= n2_reg * n2_reg;
            t_reg     <= sq_reg * cnoise_pkg::HASH_SQ + cnoise_pkg::HASH_LIN;
            h0_reg    <= n2_d2_reg * t_reg + cnoise_pkg::HASH_ADD;
            h1_reg    <= h0_reg * cnoise_pkg::LCG_MUL + cnoise_pkg::LCG_ADD;
            h0_d1_reg <= h0_reg;
            h2_reg    <= h1_reg * cnoise_pkg::LCG_MUL + cnoise_pkg::LCG_ADD;
            h0_d2_reg <= h0_d1_reg;
            h1_d1_reg <= h1_reg;
            px_reg    <= jit_pos(h0_d2_reg, ctrl.jit);
            py_reg    <= jit_pos(h1_d1_reg, ctrl.jit);
            pz_reg    <= jit_pos(h2_reg, ctrl.jit);
            mx_reg    <= mag(DX_OFF + px_reg - $signed({3'b0, fr_reg[6][0], 16'b0}));
            my_reg    <= mag(DY_OFF + py_reg - $signed({3'b0, fr_reg[6][1], 16'b0}));
            mz_reg    <= mag(DZ_OFF + pz_reg - $signed({3'b0, fr_reg[6][2], 16'b0}));
            sqx_reg   <= mx_reg * mx_reg;
            sqy_reg   <= my_reg * my_reg;
            sqz_reg   <= mz_reg * mz_reg;
            alt_reg   <= alt_next;
            key_reg   <= (ctrl.metric == cnoise_pkg::METRIC_EUCLID)
                         ? KW'(sqx_reg) + KW'(sqy_reg) + KW'(sqz_reg)
                         : KW'(alt_reg);
            f1_reg    <= f1_next;
            f2_reg    <= f2_next;
        end
    end

    assign s_out    = s_reg;
    assign frac_out = fr_reg[0];
    assign f1_out   = f1_reg;
    assign f2_out   = f2_reg;

endmodule
`default_nettype wire

### rtl/cnoise_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnoise_isqrt
// Pipelined floor square root, one result bit per stage, with the operand
// carried alongside.
// ----------------------------------------------------------------------------
module cnoise_isqrt #(
    parameter int IN_W = 38
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [IN_W-1:0]   value_in,
    output logic      [IN_W/2-1:0] root_out,
    output logic      [IN_W-1:0]   pass_out
);

    localparam int OW = IN_W / 2;

    logic [OW+1:0]   rem_reg  [0:OW-1];
    logic [OW-1:0]   root_reg [0:OW-1];
    logic [IN_W-1:0] rad_reg  [0:OW-1];
    logic [IN_W-1:0] pass_reg [0:OW-1];

    genvar k;
    generate
        for (k = 0; k < OW; k++)
        begin : g_stage
            logic [OW+1:0]   rem_prev;
            logic [OW-1:0]   root_prev;
            logic [IN_W-1:0] rad_prev;
            logic [IN_W-1:0] pass_prev;
            logic [OW+1:0]   rem_sh;
            logic [OW+1:0]   trial;

            if (k == 0)
            begin : g_first
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign rad_prev  = value_in;
                assign pass_prev = value_in;
            end
            else
            begin : g_next
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign rad_prev  = rad_reg[k-1];
                assign pass_prev = pass_reg[k-1];
            end

            assign rem_sh = {rem_prev[OW-1:0], rad_prev[IN_W-1:IN_W-2]};
            assign trial  = {root_prev, 2'b01};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rem_sh >= trial)
                    begin
                        rem_reg[k]  <= rem_sh - trial;
                        root_reg[k] <= {root_prev[OW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k]  <= rem_sh;
                        root_reg[k] <= {root_prev[OW-2:0], 1'b0};
                    end
                    rad_reg[k]  <= {rad_prev[IN_W-3:0], 2'b00};
                    pass_reg[k] <= pass_prev;
                end
            end
        end
    endgenerate

    assign root_out = root_reg[OW-1];
    assign pass_out = pass_reg[OW-1];

endmodule
`default_nettype wire

### rtl/cellular_noise_3d_evaluator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cellular_noise_3d_evaluator
// 3d cellular noise: a row of 27 neighbor cells passes the nearest and second
// nearest distance keys along, then square root, normalization and clamp.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------
//  coord     | coord_valid / coord_stall  | coord_x, coord_y, coord_z
//  noise     | noise_valid / noise_stall  | noise_value
//  cfg       | cfg_wen                    | cfg_index, cfg_data
//
//  one item per cycle sustained while no result is stalled; the path runs
//  through the shared base hash registers, the 27-cell chain and the
//  one-bit-per-stage square root of FRAC_BITS + 3 stages.
//  reset sets the configuration defaults and clears the valid pipeline; no clearing pass.
//  a stalled result freezes the whole pipeline and coord_stall follows.
// ----------------------------------------------------------------------------
module cellular_noise_3d_evaluator #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               coord_valid,
    output logic                    coord_stall,
    input  wire logic signed [31:0] coord_x,
    input  wire logic signed [31:0] coord_y,
    input  wire logic signed [31:0] coord_z,
    output logic                    noise_valid,
    input  wire logic               noise_stall,
    output logic             [16:0] noise_value,
    input  wire logic               cfg_wen,
    input  wire logic        [1:0]  cfg_index,
    input  wire logic        [16:0] cfg_data
);

    localparam int MW  = FRAC_BITS + 2;
    localparam int KW  = 2 * MW + 2;
    localparam int RW  = KW / 2;
    localparam int XW  = FRAC_BITS + 25;
    localparam int YW  = 24;
    localparam int PW  = YW + 29;
    localparam int NC  = cnoise_pkg::NUM_CELLS;
    localparam int CH_IDX = 2 + (NC - 1) + cnoise_pkg::CELL_LAT - 1;
    localparam int SQ_IDX = CH_IDX + RW;
    localparam int LAT = SQ_IDX + 5;

    logic [16:0] jitter_reg;
    logic [1:0]  metric_reg;
    logic [1:0]  mode_reg;

    logic [16:0] jit_sat;
    logic [1:0]  mi, oi;
    logic        en, accept;

    logic [LAT-1:0] vld_reg, vld_next;

    logic [31:0]      mul_reg [0:2];
    logic [2:0][15:0] fr0_reg, fr1_reg;
    logic [31:0]      s_reg;

    logic [31:0]      s_chain  [0:NC];
    logic [2:0][15:0] fr_chain [0:NC];
    logic [KW-1:0]    f1_chain [0:NC];
    logic [KW-1:0]    f2_chain [0:NC];

    cnoise_pkg::cell_ctrl_t ctrl;

    logic [RW-1:0] root1, root2;
    logic [KW-1:0] pass1, pass2;
    logic [RW-1:0] d1, d2, r_comb;

    logic [RW-1:0] r_reg;
    logic [5:0]    n_reg, n_d_reg;
    logic [YW-1:0] y_reg;
    logic [XW-1:0] x_val;
    logic [YW-1:0] lim;
    logic          clamp_reg;
    logic [PW-1:0] prod_reg;
    logic [16:0]   value_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jitter_reg <= cnoise_pkg::JIT_ONE;
            metric_reg <= cnoise_pkg::METRIC_EUCLID;
            mode_reg   <= cnoise_pkg::MODE_F1;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                cnoise_pkg::CFG_JITTER: jitter_reg <= cfg_data;
                cnoise_pkg::CFG_METRIC: metric_reg <= cfg_data[1:0];
                cnoise_pkg::CFG_MODE:   mode_reg   <= cfg_data[1:0];
                default:                ;
            endcase
        end
    end

    assign jit_sat = (jitter_reg > cnoise_pkg::JIT_ONE) ? cnoise_pkg::JIT_ONE : jitter_reg;
    // code three falls back to euclidean / f1
    assign mi = (metric_reg == 2'd3) ? cnoise_pkg::METRIC_EUCLID : metric_reg;
    assign oi = (mode_reg == 2'd3) ? cnoise_pkg::MODE_F1 : mode_reg;

    assign en          = !(noise_valid && noise_stall);
    assign coord_stall = !en;
    assign accept      = coord_valid && en;

    assign vld_next = {vld_reg[LAT-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    assign noise_valid = vld_reg[LAT-1];

    // shared hash products of the base cell
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_reg[0] <= {{16{coord_x[31]}}, coord_x[31:16]} * cnoise_pkg::HASH_KX;
            mul_reg[1] <= {{16{coord_y[31]}}, coord_y[31:16]} * cnoise_pkg::HASH_KY;
            mul_reg[2] <= {{16{coord_z[31]}}, coord_z[31:16]} * cnoise_pkg::HASH_KZ;
            fr0_reg    <= {coord_z[15:0], coord_y[15:0], coord_x[15:0]};
            s_reg      <= mul_reg[0] + mul_reg[1] + mul_reg[2];
            fr1_reg    <= fr0_reg;
        end
    end

    assign ctrl.en     = en;
    assign ctrl.jit    = jit_sat;
    assign ctrl.metric = mi;

    assign s_chain[0]  = s_reg;
    assign fr_chain[0] = fr1_reg;
    assign f1_chain[0] = '1;
    assign f2_chain[0] = '1;

    genvar k;
    generate
        for (k = 0; k < NC; k++)
        begin : g_cell
            cnoise_cell #(
                .FRAC_BITS (FRAC_BITS),
                .OX        ((k % 3) - 1),
                .OY        (((k / 3) % 3) - 1),
                .OZ        ((k / 9) - 1)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .s_in     (s_chain[k]),
                .frac_in  (fr_chain[k]),
                .f1_in    (f1_chain[k]),
                .f2_in    (f2_chain[k]),
                .s_out    (s_chain[k+1]),
                .frac_out (fr_chain[k+1]),
                .f1_out   (f1_chain[k+1]),
                .f2_out   (f2_chain[k+1])
            );
        end
    endgenerate

    cnoise_isqrt #(.IN_W(KW)) u_sqrt_f1 (
        .clk      (clk),
        .en       (en),
        .value_in (f1_chain[NC]),
        .root_out (root1),
        .pass_out (pass1)
    );

    cnoise_isqrt #(.IN_W(KW)) u_sqrt_f2 (
        .clk      (clk),
        .en       (en),
        .value_in (f2_chain[NC]),
        .root_out (root2),
        .pass_out (pass2)
    );

    // chain keys are squared distances only for euclidean
    assign d1 = (mi == cnoise_pkg::METRIC_EUCLID) ? root1 : pass1[RW-1:0];
    assign d2 = (mi == cnoise_pkg::METRIC_EUCLID) ? root2 : pass2[RW-1:0];

    always_comb
    begin
        case (oi)
            cnoise_pkg::MODE_F2:   r_comb = d2;
            cnoise_pkg::MODE_DIFF: r_comb = d2 - d1;
            default:               r_comb = d1;
        endcase
    end

    // y = (40 * r * 2^16 + n * 2^f) >> (f + 1), result = floor(y / n)
    assign x_val = XW'(r_reg) * XW'(40) * (XW'(1) << 16) + (XW'(n_reg) << FRAC_BITS);
    assign lim   = YW'({n_d_reg, 16'b0}) + YW'(n_d_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg     <= r_comb;
            n_reg     <= cnoise_pkg::norm_twentieths(mi, oi);
            y_reg     <= YW'(x_val >> (FRAC_BITS + 1));
            n_d_reg   <= n_reg;
            clamp_reg <= (y_reg >= lim);
            prod_reg  <= PW'(y_reg) * PW'(cnoise_pkg::norm_recip(n_d_reg));
            value_reg <= clamp_reg ? cnoise_pkg::JIT_ONE : prod_reg[48:32];
        end
    end

    assign noise_value = value_reg;

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        noise_valid |-> (noise_value <= 17'd65536))
        else $error("noise value above one");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[CH_IDX] |-> (f1_chain[NC] <= f2_chain[NC]))
        else $error("nearest key above second nearest");

    a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SQ_IDX] |-> ((KW'(root1) * KW'(root1) <= pass1)
                             && ((KW+1)'(root1) + 1) * ((KW+1)'(root1) + 1) > (KW+1)'(pass1)))
        else $error("square root not the floor root");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> (vld_reg == $past(vld_reg)))
        else $error("pipeline moved while stalled");

endmodule
`default_nettype wire
